// File: rtl/cfr_pkg.sv
package cfr_pkg;

  // frame geometry
  localparam int unsigned FRAME_CAPACITY_DEF = 16;
  localparam int unsigned SHORT_FRAME_LEN    = 4;
  localparam int unsigned MOVE_FRAME_LEN     = 12;

  // register reset values
  localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
  localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
  localparam logic [7:0] MOVEMENT_CODE_RST = 8'h01;

  // register indexes
  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_MOVEMENT_CODE = 2'd2
  } cfr_reg_e;

  // event codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_MOVE     = 3'd1,
    EV_OTHER    = 3'd2,
    EV_CHECKSUM = 3'd3,
    EV_OVERFLOW = 3'd4
  } cfr_event_e;

  // configuration as seen by the frame logic
  typedef struct packed {
    logic [7:0] header_first;
    logic [7:0] header_second;
    logic [7:0] movement_code;
  } cfr_cfg_t;

  // one result word
  typedef struct packed {
    cfr_event_e  event_res;
    logic [7:0]  command_type;
    logic [31:0] linear_bits;
    logic [31:0] angular_bits;
  } cfr_result_t;

endpackage

// File: rtl/cfr_if.sv
// received byte channel
interface cfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// frame event channel
interface cfr_event_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  command_type;
  logic [31:0] linear_bits;
  logic [31:0] angular_bits;

  modport source (output valid, output event_res, output command_type,
                  output linear_bits, output angular_bits, input ready);
  modport sink (input valid, input event_res, input command_type,
                input linear_bits, input angular_bits, output ready);
endinterface

// File: rtl/command_frame_receiver_top.sv
// channel   dir  payload                                              word
// rx_i      in   rx_byte[7:0]                                         one received byte
// ev_o      out  event_res[2:0] command_type[7:0] linear_bits[31:0]   one event per byte
//                angular_bits[31:0]
// cfg       in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i[7:0]            register write
//
// One byte per cycle sustained while ev_o is not stalled; each byte is held in the
// input register and its event is registered in the output register.
// The frame update (window slide, 11-byte XOR, compare) is one combinational
// pass between those two registers.
// Reset clears the fill count, both valid flags and loads register defaults.
// A stalled output holds the input register, which then deasserts rx_i.ready.
module command_frame_receiver_top
  import cfr_pkg::*;
#(
  parameter int unsigned FrameCapacity = FRAME_CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cfr_byte_if.sink    rx_i,
  cfr_event_if.source ev_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_can_load;
  logic        advance;
  cfr_cfg_t    cfg;
  cfr_result_t res;

  // input register handshake
  assign advance    = in_valid_q && out_can_load;
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  cfr_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  cfr_frame_core #(
    .FrameCapacity (FrameCapacity)
  ) u_frame_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  cfr_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (advance),
    .res_i      (res),
    .can_load_o (out_can_load),
    .ev_o       (ev_o)
  );

  // a processed byte always shows up as an output word
  assert property (@(posedge clk_i) disable iff (!rst_ni) advance |=> ev_o.valid)
    else $error("processed byte produced no output word");

  // frame length never exceeds the store, so the store never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev_o.valid |-> ev_o.event_res != EV_OVERFLOW)
    else $error("frame store overflowed");

  // a byte with no event carries a zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_o.valid && ev_o.event_res == EV_NONE) |->
      (ev_o.command_type == 8'd0 && ev_o.linear_bits == 32'd0 &&
       ev_o.angular_bits == 32'd0))
    else $error("payload set without an event");

endmodule

// File: rtl/cfr_cfg_regs.sv
module cfr_cfg_regs
  import cfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  output cfr_cfg_t   cfg_o
);

  cfr_cfg_t cfg_q, cfg_d;

  // decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HEADER_FIRST:  cfg_d.header_first  = cfg_data_i;
        REG_HEADER_SECOND: cfg_d.header_second = cfg_data_i;
        REG_MOVEMENT_CODE: cfg_d.movement_code = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first  <= HEADER_FIRST_RST;
      cfg_q.header_second <= HEADER_SECOND_RST;
      cfg_q.movement_code <= MOVEMENT_CODE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/cfr_frame_core.sv
module cfr_frame_core
  import cfr_pkg::*;
#(
  parameter int unsigned FrameCapacity = FRAME_CAPACITY_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        advance_i,
  input  logic [7:0]  rx_byte_i,
  input  cfr_cfg_t    cfg_i,
  output cfr_result_t res_o
);

  localparam int unsigned CntW = $clog2(FrameCapacity + 1);

  logic [CntW-1:0] count_q, count_d, count_inc;
  logic [7:0]      store_q [FrameCapacity];
  logic [7:0]      store_d [FrameCapacity];
  logic [7:0]      merged  [FrameCapacity];
  logic            hdr_ok;
  logic            is_move;
  logic [7:0]      x_short;
  logic [7:0]      x_long;
  cfr_result_t     res;

  // store with the new byte placed at the fill position
  always_comb begin
    for (int i = 0; i < FrameCapacity; i++) begin
      merged[i] = (CntW'(i) == count_q) ? rx_byte_i : store_q[i];
    end
  end

  // header, command and checksum terms
  always_comb begin
    x_long = 8'd0;
    for (int i = 0; i < MOVE_FRAME_LEN - 1; i++) begin
      x_long = x_long ^ merged[i];
    end
  end

  assign count_inc = count_q + CntW'(1);
  assign hdr_ok    = (merged[0] == cfg_i.header_first) &&
                     (merged[1] == cfg_i.header_second);
  assign is_move   = (merged[2] == cfg_i.movement_code);
  assign x_short   = merged[0] ^ merged[1] ^ merged[2];

  // next state and result for one byte
  always_comb begin
    count_d = count_q;
    store_d = store_q;
    res     = '0;
    res.event_res = EV_NONE;
    if (count_q == CntW'(FrameCapacity)) begin
      // full store: drop the byte and start over
      count_d       = '0;
      res.event_res = EV_OVERFLOW;
    end else begin
      store_d = merged;
      count_d = count_inc;
      if (count_inc >= CntW'(2)) begin
        if (hdr_ok) begin
          if (count_inc >= CntW'(SHORT_FRAME_LEN)) begin
            if (!is_move) begin
              res.command_type = merged[2];
              res.event_res    = (x_short == merged[SHORT_FRAME_LEN-1]) ? EV_OTHER
                                                                        : EV_CHECKSUM;
              count_d          = '0;
            end else if (count_inc >= CntW'(MOVE_FRAME_LEN)) begin
              res.command_type = merged[2];
              count_d          = '0;
              if (x_long == merged[MOVE_FRAME_LEN-1]) begin
                res.event_res    = EV_MOVE;
                res.linear_bits  = {merged[6], merged[5], merged[4], merged[3]};
                res.angular_bits = {merged[10], merged[9], merged[8], merged[7]};
              end else begin
                res.event_res = EV_CHECKSUM;
              end
            end
          end
        end else begin
          // header mismatch: slide the window by one byte
          for (int i = 0; i < FrameCapacity - 1; i++) begin
            store_d[i] = merged[i+1];
          end
          count_d = count_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
    end
  end

  // store contents are only read below the fill count
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      store_q <= store_d;
    end
  end

  assign res_o = res;

endmodule

// File: rtl/cfr_out_reg.sv
module cfr_out_reg
  import cfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  cfr_result_t res_i,
  output logic        can_load_o,
  cfr_event_if.source ev_o
);

  logic        valid_q;
  cfr_result_t res_q;

  // free when empty or the word leaves this cycle
  assign can_load_o = !valid_q || ev_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ev_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign ev_o.valid        = valid_q;
  assign ev_o.event_res    = res_q.event_res;
  assign ev_o.command_type = res_q.command_type;
  assign ev_o.linear_bits  = res_q.linear_bits;
  assign ev_o.angular_bits = res_q.angular_bits;

endmodule

// File: sim/tb_top.sv
module tb_top;
  import cfr_pkg::*;

  localparam int unsigned CAPACITY     = FRAME_CAPACITY_DEF;
  localparam int unsigned PHASE_BYTES  = 270;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned FULL_FRAME   = 64;
  localparam int unsigned REPORT_MAX   = 10;
  // index past the last register, writes to it must be ignored
  localparam logic [1:0]  REG_SPARE    = 2'd3;

  typedef bit [7:0] octet_q_t[$];

  // frame assembler model and event scoreboard
  class frame_scoreboard;
    bit [7:0]    hdr_first;
    bit [7:0]    hdr_second;
    bit [7:0]    move_code;
    bit [7:0]    held[CAPACITY];
    int unsigned held_cnt;
    cfr_result_t expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned moves;
    int unsigned shorts;
    int unsigned bad_sums;

    function new();
      hdr_first  = HEADER_FIRST_RST;
      hdr_second = HEADER_SECOND_RST;
      move_code  = MOVEMENT_CODE_RST;
      errors     = 0;
      checked    = 0;
      moves      = 0;
      shorts     = 0;
      bad_sums   = 0;
      clear_store();
    endfunction

    function void clear_store();
      held_cnt = 0;
      foreach (held[i]) held[i] = 8'h00;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_HEADER_FIRST:  hdr_first = val;
        REG_HEADER_SECOND: hdr_second = val;
        REG_MOVEMENT_CODE: move_code = val;
        default: ;
      endcase
    endfunction

    // advance the frame store by one received byte and queue its event
    function void note_byte(bit [7:0] b);
      cfr_result_t r;
      bit [7:0]    x;
      bit [7:0]    cmd;
      int unsigned need;
      int unsigned i;
      r = '0;
      r.event_res = EV_NONE;
      if (held_cnt < CAPACITY) begin
        held[held_cnt] = b;
        held_cnt++;
        if (held_cnt >= 2) begin
          if (held[0] == hdr_first && held[1] == hdr_second) begin
            if (held_cnt >= SHORT_FRAME_LEN) begin
              cmd  = held[2];
              need = (cmd == move_code) ? MOVE_FRAME_LEN : SHORT_FRAME_LEN;
              if (held_cnt >= need) begin
                x = 8'h00;
                for (i = 0; i + 1 < need; i++) x ^= held[i];
                r.command_type = cmd;
                if (x == held[need-1]) begin
                  if (cmd == move_code) begin
                    r.event_res    = EV_MOVE;
                    r.linear_bits  = {held[6], held[5], held[4], held[3]};
                    r.angular_bits = {held[10], held[9], held[8], held[7]};
                  end else begin
                    r.event_res = EV_OTHER;
                  end
                end else begin
                  r.event_res = EV_CHECKSUM;
                end
                clear_store();
              end
            end
          end else begin
            // header hunt: slide the window by one byte
            for (i = 1; i < held_cnt; i++) held[i-1] = held[i];
            held_cnt--;
          end
        end
      end else begin
        clear_store();
        r.event_res = EV_OVERFLOW;
      end
      expected_q.push_back(r);
    endfunction

    // compare one accepted event word against the oldest prediction
    function void check_event(cfr_result_t act);
      cfr_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected event: ev=%0d cmd=%02h lin=%08h ang=%08h",
                   act.event_res, act.command_type, act.linear_bits, act.angular_bits);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      if (exp_r.event_res !== act.event_res || exp_r.command_type !== act.command_type ||
          exp_r.linear_bits !== act.linear_bits ||
          exp_r.angular_bits !== act.angular_bits) begin
        errors++;
        if (errors <= REPORT_MAX) begin
          $display("event mismatch: exp ev=%0d cmd=%02h lin=%08h ang=%08h",
                   exp_r.event_res, exp_r.command_type, exp_r.linear_bits,
                   exp_r.angular_bits);
          $display("                got ev=%0d cmd=%02h lin=%08h ang=%08h",
                   act.event_res, act.command_type, act.linear_bits,
                   act.angular_bits);
        end
      end
      case (exp_r.event_res)
        EV_MOVE:     moves++;
        EV_OTHER:    shorts++;
        EV_CHECKSUM: bad_sums++;
        default: ;
      endcase
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [7:0]  cfg_data;

  cfr_byte_if  rx_if();
  cfr_event_if ev_if();

  frame_scoreboard sb;
  int unsigned     bytes_sent;
  int unsigned     src_idle_pct;
  int unsigned     sink_idle_pct;
  bit              hold_req;
  int unsigned     cycles;

  command_frame_receiver_top #(
    .FrameCapacity(CAPACITY)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .rx_i       (rx_if),
    .ev_o       (ev_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped after %0d cycles", cycles);
    $display("Some tests failed");
    $finish;
  end

  // offer one byte, wait until the word is accepted
  task automatic send_byte(input bit [7:0] b);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      rx_if.valid <= 1'b0;
      @(posedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (rx_if.ready !== 1'b1);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  // frame body plus xor checksum, optionally corrupted or cut short
  task automatic send_frame(input octet_q_t body, input bit bad_sum,
                            input int unsigned cut);
    bit [7:0]    x;
    int unsigned i;
    x = 8'h00;
    foreach (body[k]) x ^= body[k];
    if (bad_sum) x ^= 8'($urandom_range(255, 1));
    body.push_back(x);
    for (i = 0; i < body.size() && i < cut; i++) send_byte(body[i]);
  endtask

  // random frame body built on the current register setting
  task automatic make_body(output octet_q_t body);
    bit [7:0] cmd;
    cmd = ($urandom_range(99) < 45) ? sb.move_code : 8'($urandom);
    body = {};
    body.push_back(sb.hdr_first);
    body.push_back(sb.hdr_second);
    body.push_back(cmd);
    if (cmd == sb.move_code)
      repeat (MOVE_FRAME_LEN - SHORT_FRAME_LEN) body.push_back(8'($urandom));
  endtask

  // wait until every event is back and the pipeline is empty
  task automatic drain();
    rx_if.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic write_config(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [7:0] mc);
    put_reg(REG_HEADER_FIRST, h1);
    put_reg(REG_HEADER_SECOND, h2);
    put_reg(REG_MOVEMENT_CODE, mc);
    put_reg(REG_SPARE, 8'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // event sink: checks accepted words, random back-pressure, long hold-off
  initial begin
    int unsigned hold_left;
    cfr_result_t act;
    hold_left = 0;
    ev_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (ev_if.valid === 1'b1 && ev_if.ready === 1'b1) begin
        act.event_res    = cfr_event_e'(ev_if.event_res);
        act.command_type = ev_if.command_type;
        act.linear_bits  = ev_if.linear_bits;
        act.angular_bits = ev_if.angular_bits;
        sb.check_event(act);
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        ev_if.ready <= 1'b0;
      end else begin
        ev_if.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // main sequence
  initial begin
    octet_q_t    body;
    int unsigned ph;
    int unsigned phase_start;
    int unsigned pick;
    sb            = new();
    bytes_sent    = 0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hold_req      = 1'b0;
    rst_n         = 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= REG_HEADER_FIRST;
    cfg_data      <= 8'h00;
    rx_if.valid   <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme bytes, header slide, good and bad short frames, movement frame
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hAA);
    body = {8'hAA, 8'h55, 8'h02};
    send_frame(body, 1'b0, FULL_FRAME);
    body = {8'hAA, 8'h55, 8'hFF};
    send_frame(body, 1'b1, FULL_FRAME);
    body = {8'hAA, 8'h55, 8'h01, 8'h00, 8'h00, 8'h00, 8'h80,
            8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_frame(body, 1'b0, FULL_FRAME);
    drain();

    // random phases over several register settings and idle patterns
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_config(8'h00, 8'h00, 8'h00);
        1: write_config(8'hFF, 8'hFF, 8'hFF);
        3: write_config(HEADER_FIRST_RST, HEADER_SECOND_RST, MOVEMENT_CODE_RST);
        5: write_config(8'h00, 8'hFF, 8'h80);
        default: write_config(8'($urandom), 8'($urandom), 8'($urandom));
      endcase
      if (ph < 2) begin
        src_idle_pct  = 14;
        sink_idle_pct = 86;
      end else if (ph < 4) begin
        src_idle_pct  = 86;
        sink_idle_pct = 14;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      if (ph == 4) hold_req = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 65) begin
          make_body(body);
          send_frame(body, $urandom_range(99) < 15, FULL_FRAME);
        end else if (pick < 78) begin
          // truncated frame, the next one runs into it
          make_body(body);
          send_frame(body, 1'b0, $urandom_range(body.size(), 1));
        end else if (pick < 90) begin
          repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
        end else begin
          // false start on the first header byte
          send_byte(sb.hdr_first);
          if ($urandom_range(1)) send_byte(sb.hdr_first);
          send_byte(8'($urandom));
        end
      end
      drain();
    end

    $display("covered %0d bytes over %0d register settings with mixed stalls",
             bytes_sent, NUM_PHASES + 1);
    $display("%0d events checked: %0d movement, %0d short, %0d checksum errors",
             sb.checked, sb.moves, sb.shorts, sb.bad_sums);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d events missing", sb.errors, sb.expected_q.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cfr_pkg.sv
rtl/cfr_if.sv
rtl/cfr_cfg_regs.sv
rtl/cfr_frame_core.sv
rtl/cfr_out_reg.sv
rtl/command_frame_receiver_top.sv
sim/tb_top.sv
